/* rtl/stt_pkg.sv */
package stt_pkg;

	localparam logic [4:0] KIND_LPAREN     = 5'd0;
	localparam logic [4:0] KIND_RPAREN     = 5'd1;
	localparam logic [4:0] KIND_LBRACE     = 5'd2;
	localparam logic [4:0] KIND_RBRACE     = 5'd3;
	localparam logic [4:0] KIND_COMMA      = 5'd4;
	localparam logic [4:0] KIND_DOT        = 5'd5;
	localparam logic [4:0] KIND_MINUS      = 5'd6;
	localparam logic [4:0] KIND_PLUS       = 5'd7;
	localparam logic [4:0] KIND_SEMI       = 5'd8;
	localparam logic [4:0] KIND_SLASH      = 5'd9;
	localparam logic [4:0] KIND_STAR       = 5'd10;
	localparam logic [4:0] KIND_BANG       = 5'd11;
	localparam logic [4:0] KIND_BANG_EQ    = 5'd12;
	localparam logic [4:0] KIND_EQUAL      = 5'd13;
	localparam logic [4:0] KIND_EQ_EQ      = 5'd14;
	localparam logic [4:0] KIND_GREATER    = 5'd15;
	localparam logic [4:0] KIND_GREATER_EQ = 5'd16;
	localparam logic [4:0] KIND_LESS       = 5'd17;
	localparam logic [4:0] KIND_LESS_EQ    = 5'd18;
	localparam logic [4:0] KIND_IDENT      = 5'd19;
	localparam logic [4:0] KIND_NUMBER     = 5'd20;
	localparam logic [4:0] KIND_ERROR      = 5'd21;
	localparam logic [4:0] KIND_END        = 5'd22;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_US    = 8'h5F;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_US);
	endfunction

	function automatic logic [4:0] punct_kind(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h28: k = KIND_LPAREN;
			8'h29: k = KIND_RPAREN;
			8'h7B: k = KIND_LBRACE;
			8'h7D: k = KIND_RBRACE;
			8'h2C: k = KIND_COMMA;
			8'h2E: k = KIND_DOT;
			8'h2D: k = KIND_MINUS;
			8'h2B: k = KIND_PLUS;
			8'h3B: k = KIND_SEMI;
			8'h2A: k = KIND_STAR;
			default: k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

/* rtl/stt_front.sv */
module stt_front #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           q_full,
	output logic                           push,
	output logic [2*(5+3*OFFSET_BITS):0]   bundle
);

	typedef struct packed {
		logic [4:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] length;
		logic [OFFSET_BITS-1:0] line;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} bundle_t;

	typedef enum logic [3:0] {
		M_IDLE, M_COMMENT, M_NUMBER, M_IDENT, M_SLASH,
		M_BANG, M_EQUAL, M_GREATER, M_LESS
	} mode_t;

	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [OFFSET_BITS-1:0] ONE  = OFFSET_BITS'(1);

	mode_t                  mode_q, mode_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, pend_q, pend_d, line_q, line_d;
	logic [OFFSET_BITS-1:0] held, held_inc, pos_inc;
	logic                   accept, done, pre_v, post_v;
	tok_t                   pre, post;
	bundle_t                b;

	assign accept   = in_valid & ~q_full;
	assign in_stall = q_full;

	always_comb begin
		held     = pos_q - pend_q;
		held_inc = (held == OMAX) ? held : held + ONE;
		pos_inc  = (pos_q == OMAX) ? pos_q : pos_q + ONE;
		done     = 1'b0;
		pre_v    = 1'b0;
		pre      = '{kind: stt_pkg::KIND_ERROR, start: pend_q, length: held, line: line_q};
		post_v   = 1'b0;
		post     = '{kind: stt_pkg::KIND_ERROR, start: pos_q, length: ONE, line: line_q};
		mode_d   = mode_q;
		pos_d    = pos_q;
		pend_d   = pend_q;
		line_d   = line_q;
		case (mode_q)
			M_COMMENT: begin
				if (text_byte != stt_pkg::CH_NL && text_byte != stt_pkg::CH_NUL)
					done = 1'b1;
			end
			M_NUMBER: begin
				if (stt_pkg::is_digit(text_byte)) done = 1'b1;
				else begin
					pre_v    = 1'b1;
					pre.kind = stt_pkg::KIND_NUMBER;
				end
			end
			M_IDENT: begin
				if (stt_pkg::is_alpha(text_byte) || stt_pkg::is_digit(text_byte)) done = 1'b1;
				else begin
					pre_v    = 1'b1;
					pre.kind = stt_pkg::KIND_IDENT;
				end
			end
			M_SLASH: begin
				if (text_byte == stt_pkg::CH_SLASH) begin
					done   = 1'b1;
					mode_d = M_COMMENT;
				end else begin
					pre_v    = 1'b1;
					pre.kind = stt_pkg::KIND_SLASH;
				end
			end
			M_BANG, M_EQUAL, M_GREATER, M_LESS: begin
				pre_v = 1'b1;
				if (text_byte == stt_pkg::CH_EQ) begin
					done       = 1'b1;
					mode_d     = M_IDLE;
					pre.length = held_inc;
					case (mode_q)
						M_BANG:    pre.kind = stt_pkg::KIND_BANG_EQ;
						M_EQUAL:   pre.kind = stt_pkg::KIND_EQ_EQ;
						M_GREATER: pre.kind = stt_pkg::KIND_GREATER_EQ;
						default:   pre.kind = stt_pkg::KIND_LESS_EQ;
					endcase
				end else begin
					case (mode_q)
						M_BANG:    pre.kind = stt_pkg::KIND_BANG;
						M_EQUAL:   pre.kind = stt_pkg::KIND_EQUAL;
						M_GREATER: pre.kind = stt_pkg::KIND_GREATER;
						default:   pre.kind = stt_pkg::KIND_LESS;
					endcase
				end
			end
			default: ;
		endcase

		if (done) begin
			pos_d = pos_inc;
		end else begin
			mode_d = M_IDLE;
			if (text_byte == stt_pkg::CH_NUL) begin
				post_v      = 1'b1;
				post.kind   = stt_pkg::KIND_END;
				post.length = '0;
				pos_d       = '0;
				pend_d      = '0;
				line_d      = ONE;
			end else begin
				pos_d = pos_inc;
				if (text_byte == stt_pkg::CH_SPACE || text_byte == stt_pkg::CH_CR ||
				    text_byte == stt_pkg::CH_TAB) begin
				end else if (text_byte == stt_pkg::CH_NL) begin
					line_d = (line_q == OMAX) ? line_q : line_q + ONE;
				end else if (stt_pkg::is_digit(text_byte)) begin
					pend_d = pos_q;
					mode_d = M_NUMBER;
				end else if (stt_pkg::is_alpha(text_byte)) begin
					pend_d = pos_q;
					mode_d = M_IDENT;
				end else if (text_byte == stt_pkg::CH_SLASH) begin
					pend_d = pos_q;
					mode_d = M_SLASH;
				end else if (text_byte == stt_pkg::CH_BANG) begin
					pend_d = pos_q;
					mode_d = M_BANG;
				end else if (text_byte == stt_pkg::CH_EQ) begin
					pend_d = pos_q;
					mode_d = M_EQUAL;
				end else if (text_byte == stt_pkg::CH_GT) begin
					pend_d = pos_q;
					mode_d = M_GREATER;
				end else if (text_byte == stt_pkg::CH_LT) begin
					pend_d = pos_q;
					mode_d = M_LESS;
				end else begin
					post_v    = 1'b1;
					post.kind = stt_pkg::punct_kind(text_byte);
				end
			end
		end

		b.two = pre_v & post_v;
		b.t0  = pre_v ? pre : post;
		b.t1  = post;
	end

	assign push   = accept & (pre_v | post_v);
	assign bundle = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			pend_q <= '0;
			line_q <= ONE;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q  <= pos_d;
			pend_q <= pend_d;
			line_q <= line_d;
		end
	end

endmodule

/* rtl/stt_queue.sv */
module stt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] head
);

	logic [W-1:0]             mem_q [stt_pkg::Q_DEPTH];
	logic [stt_pkg::Q_AW-1:0] wptr_q, rptr_q;
	logic [stt_pkg::Q_AW:0]   cnt_q;

	assign full     = (cnt_q == (stt_pkg::Q_AW+1)'(stt_pkg::Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/stt_back.sv */
module stt_back #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_nonempty,
	input  logic [2*(5+3*OFFSET_BITS):0] head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [4:0]                   token_kind,
	output logic [OFFSET_BITS-1:0]       token_start,
	output logic [OFFSET_BITS-1:0]       token_length,
	output logic [OFFSET_BITS-1:0]       token_line,
	output logic                         last_of_run
);

	typedef struct packed {
		logic [4:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] length;
		logic [OFFSET_BITS-1:0] line;
	} tok_t;

	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} bundle_t;

	bundle_t hd;
	tok_t    sel, tok_q;
	logic    load, valid_q, half_q, last_q;

	assign hd   = head;
	assign load = ~valid_q | ~out_stall;
	assign pop  = load & q_nonempty & (half_q | ~hd.two);
	assign sel  = half_q ? hd.t1 : hd.t0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= q_nonempty;
			if (q_nonempty) half_q <= ~half_q & hd.two;
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_nonempty) begin
			tok_q  <= sel;
			last_q <= half_q | ~hd.two;
		end
	end

	assign out_valid    = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign token_line   = tok_q.line;
	assign last_of_run  = last_q;

endmodule

/* rtl/source_text_tokenizer_top.sv */
// Source text tokenizer.
// Input channel: one text byte per item on text_byte (in_valid/in_stall).
// A zero byte ends the text; the scanner then returns to its reset state.
// Output channel: one token per item (out_valid/out_stall) with kind, start
// offset, length and ending line; last_of_run marks the final token caused
// by one input byte (a byte causes zero, one or two tokens).
// A token enters the queue when the byte ending it is taken, then moves
// to the output register. Throughput: one byte per cycle unless the queue
// is full; one token leaves per cycle unless out_stall is high, so a byte
// that closes a pending token and emits another yields two. A four-entry
// queue absorbs these bursts; in_stall rises only when that queue is full.
// Reset: scanner idle, offset 0, line 1, queue and output register empty.
// A stalled output holds its token; the scanner keeps taking bytes until
// the queue fills.
module source_text_tokenizer_top #(
	parameter int OFFSET_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             text_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [4:0]             token_kind,
	output logic [OFFSET_BITS-1:0] token_start,
	output logic [OFFSET_BITS-1:0] token_length,
	output logic [OFFSET_BITS-1:0] token_line,
	output logic                   last_of_run
);

	localparam int BW = 2*(5+3*OFFSET_BITS)+1;

	logic          push, full, pop, nonempty;
	logic [BW-1:0] wdata, head;

	stt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.text_byte(text_byte),
		.q_full   (full),
		.push     (push),
		.bundle   (wdata)
	);

	stt_queue #(.W(BW)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (wdata),
		.full    (full),
		.pop     (pop),
		.nonempty(nonempty),
		.head    (head)
	);

	stt_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (nonempty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_start (token_start),
		.token_length(token_length),
		.token_line  (token_line),
		.last_of_run (last_of_run)
	);

endmodule

/* bench/token_checker.sv */
module token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [4:0]  token_kind,
	input  logic [15:0] token_start,
	input  logic [15:0] token_length,
	input  logic [15:0] token_line,
	input  logic        last_of_run,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SAT = 65535;

	typedef enum logic [3:0] {
		SC_IDLE, SC_COMMENT, SC_NUMBER, SC_IDENT, SC_SLASH,
		SC_BANG, SC_EQUAL, SC_GREATER, SC_LESS
	} scan_mode_t;

	typedef struct {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	scan_mode_t  mode;
	int unsigned byte_pos;
	int unsigned pend_start;
	int unsigned line_no;
	token_t      expected_tokens[$];
	token_t      byte_tokens[$];

	function automatic int unsigned bump(input int unsigned v);
		return (v >= SAT) ? SAT : v + 1;
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic word_char(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
			(c == stt_pkg::CH_US);
	endfunction

	function automatic logic [4:0] punct_of(input logic [7:0] c);
		case (c)
			"(": return stt_pkg::KIND_LPAREN;
			")": return stt_pkg::KIND_RPAREN;
			"{": return stt_pkg::KIND_LBRACE;
			"}": return stt_pkg::KIND_RBRACE;
			",": return stt_pkg::KIND_COMMA;
			".": return stt_pkg::KIND_DOT;
			"-": return stt_pkg::KIND_MINUS;
			"+": return stt_pkg::KIND_PLUS;
			";": return stt_pkg::KIND_SEMI;
			"*": return stt_pkg::KIND_STAR;
			default: return stt_pkg::KIND_ERROR;
		endcase
	endfunction

	function automatic void add_token(input logic [4:0] kind, input int unsigned start,
			input int unsigned len);
		token_t t;
		t.kind = kind;
		t.start = start[15:0];
		t.length = (len > SAT) ? SAT[15:0] : len[15:0];
		t.line = line_no[15:0];
		t.last = 1'b0;
		byte_tokens.push_back(t);
	endfunction

	task automatic scan_byte(input logic [7:0] c);
		int unsigned pos;
		int unsigned held;
		logic [4:0]  base;
		logic        taken;
		token_t      t;
		byte_tokens.delete();
		pos = byte_pos;
		held = pos - pend_start;
		taken = 1'b0;
		case (mode)
			SC_COMMENT: begin
				if (c != stt_pkg::CH_NL && c != stt_pkg::CH_NUL)
					taken = 1'b1;
			end
			SC_NUMBER: begin
				if (digit_char(c))
					taken = 1'b1;
				else
					add_token(stt_pkg::KIND_NUMBER, pend_start, held);
			end
			SC_IDENT: begin
				if (word_char(c) || digit_char(c))
					taken = 1'b1;
				else
					add_token(stt_pkg::KIND_IDENT, pend_start, held);
			end
			SC_SLASH: begin
				if (c == stt_pkg::CH_SLASH) begin
					mode = SC_COMMENT;
					taken = 1'b1;
				end else begin
					add_token(stt_pkg::KIND_SLASH, pend_start, held);
				end
			end
			SC_BANG, SC_EQUAL, SC_GREATER, SC_LESS: begin
				base = (mode == SC_BANG) ? stt_pkg::KIND_BANG :
				       (mode == SC_EQUAL) ? stt_pkg::KIND_EQUAL :
				       (mode == SC_GREATER) ? stt_pkg::KIND_GREATER : stt_pkg::KIND_LESS;
				if (c == stt_pkg::CH_EQ) begin
					add_token(base + 5'd1, pend_start, held + 1);
					mode = SC_IDLE;
					taken = 1'b1;
				end else begin
					add_token(base, pend_start, held);
				end
			end
			default: ;
		endcase

		if (taken) begin
			byte_pos = bump(pos);
		end else if (c == stt_pkg::CH_NUL) begin
			add_token(stt_pkg::KIND_END, pos, 0);
			mode = SC_IDLE;
			byte_pos = 0;
			pend_start = 0;
			line_no = 1;
		end else begin
			mode = SC_IDLE;
			if (c == stt_pkg::CH_NL) begin
				line_no = bump(line_no);
			end else if (digit_char(c)) begin
				pend_start = pos;
				mode = SC_NUMBER;
			end else if (word_char(c)) begin
				pend_start = pos;
				mode = SC_IDENT;
			end else if (c == stt_pkg::CH_SLASH) begin
				pend_start = pos;
				mode = SC_SLASH;
			end else if (c == stt_pkg::CH_BANG) begin
				pend_start = pos;
				mode = SC_BANG;
			end else if (c == stt_pkg::CH_EQ) begin
				pend_start = pos;
				mode = SC_EQUAL;
			end else if (c == stt_pkg::CH_GT) begin
				pend_start = pos;
				mode = SC_GREATER;
			end else if (c == stt_pkg::CH_LT) begin
				pend_start = pos;
				mode = SC_LESS;
			end else if (c != stt_pkg::CH_SPACE && c != stt_pkg::CH_CR &&
					c != stt_pkg::CH_TAB) begin
				add_token(punct_of(c), pos, 1);
			end
			byte_pos = bump(pos);
		end

		if (byte_tokens.size() > 0) begin
			t = byte_tokens.pop_back();
			t.last = 1'b1;
			byte_tokens.push_back(t);
		end
		foreach (byte_tokens[i])
			expected_tokens.push_back(byte_tokens[i]);
	endtask

	task automatic check_token();
		token_t want;
		if (expected_tokens.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected token kind %0d start %0d len %0d line %0d last %0b",
					$realtime, token_kind, token_start, token_length, token_line, last_of_run);
		end else begin
			want = expected_tokens.pop_front();
			if (want.kind !== token_kind || want.start !== token_start ||
					want.length !== token_length || want.line !== token_line ||
					want.last !== last_of_run) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: token mismatch exp %0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0b",
						$realtime, want.kind, want.start, want.length, want.line, want.last,
						token_kind, token_start, token_length, token_line, last_of_run);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = SC_IDLE;
			byte_pos = 0;
			pend_start = 0;
			line_no = 1;
			fail_count = 0;
			expected_tokens.delete();
		end else begin
			if (in_valid && !in_stall)
				scan_byte(text_byte);
			if (out_valid && !out_stall)
				check_token();
		end
		outstanding = expected_tokens.size();
	end

endmodule

/* bench/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_byte;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic        last_of_run;
	int          fail_count;
	int          outstanding;
	int          bytes_sent;
	logic        burst;

	source_text_tokenizer_top uut (.*);

	token_checker chk (.*);

	initial begin
		clk = 1'b0;
		in_valid = 1'b0;
		text_byte = 8'h00;
		out_stall = 1'b0;
		burst = 1'b0;
		arst_n = 1'b0;
		bytes_sent = 0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_stall <= !burst && ($urandom_range(0, 99) < 31);

	task automatic send_byte(input logic [7:0] b);
		while (!burst && $urandom_range(0, 99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] word_byte();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		return stt_pkg::CH_US;
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	// one lexically sensible chunk, plus some noise and stray bytes
	task automatic send_piece();
		string punct;
		string cmp;
		logic [7:0] b;
		int n;
		punct = "(){},.-+;*";
		cmp = "!=<>";
		case ($urandom_range(0, 11))
			0, 1: begin
				n = $urandom_range(1, 6);
				send_byte(word_byte());
				repeat (n - 1)
					send_byte($urandom_range(0, 2) == 0 ? digit_byte() : word_byte());
			end
			2: begin
				n = $urandom_range(1, 5);
				repeat (n)
					send_byte(digit_byte());
			end
			3: send_byte(punct[$urandom_range(0, 9)]);
			4, 5: begin
				send_byte(cmp[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1))
					send_byte(stt_pkg::CH_EQ);
			end
			6: begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					case ($urandom_range(0, 2))
						0: send_byte(stt_pkg::CH_SPACE);
						1: send_byte(stt_pkg::CH_TAB);
						default: send_byte(stt_pkg::CH_CR);
					endcase
				end
			end
			7: send_byte(stt_pkg::CH_NL);
			8: begin
				send_text("//");
				n = $urandom_range(0, 8);
				repeat (n) begin
					b = 8'($urandom_range(1, 255));
					send_byte(b == stt_pkg::CH_NL ? stt_pkg::CH_SPACE : b);
				end
				if ($urandom_range(0, 3) != 0)
					send_byte(stt_pkg::CH_NL);
			end
			9: send_byte(8'($urandom_range(1, 255)));
			10: send_byte(stt_pkg::CH_SLASH);
			default: send_byte(stt_pkg::CH_NUL);
		endcase
	endtask

	initial begin
		int base;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// punctuation, then a slash closed by end of text
		send_text("(){},.-+;*/");
		send_byte(stt_pkg::CH_NUL);
		// all comparison forms, number running into a name, errors, open comment
		send_text("!=!<=<>>====9a");
		send_byte(stt_pkg::CH_CR);
		send_text("@");
		send_byte(8'hFF);
		send_byte(8'h80);
		send_text("//");
		send_byte(stt_pkg::CH_NUL);

		base = bytes_sent;
		while (bytes_sent < base + 540) begin
			burst = (bytes_sent >= base + 200) && (bytes_sent < base + 350);
			send_piece();
		end
		burst = 1'b0;
		send_byte(stt_pkg::CH_NUL);

		// longer name, then several newlines and a short statement
		send_text("a");
		repeat (20)
			send_text("b");
		repeat (5)
			send_byte(stt_pkg::CH_NL);
		send_text("foo <= 7;");
		send_byte(stt_pkg::CH_NUL);
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
